// ----- sv/ubxd_pkg.sv -----
// Package for the UBX-style frame deframer: parse phases, status and kind codes,
// configuration register indexes and their reset values.
// No dependencies; compile before the interfaces and modules.
package ubxd_pkg;

  // Parse phases, one-hot
  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_SYNC = 6'b000010,
    PH_HEAD = 6'b000100,
    PH_PAY  = 6'b001000,
    PH_CKA  = 6'b010000,
    PH_CKB  = 6'b100000
  } phase_t;

  // Result item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Frame-end status codes
  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_BAD      = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // Header byte positions
  localparam logic [1:0] HDR_CLASS  = 2'd0;
  localparam logic [1:0] HDR_ID     = 2'd1;
  localparam logic [1:0] HDR_LEN_LO = 2'd2;
  localparam logic [1:0] HDR_LEN_HI = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND_RESET = 8'h62;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

endpackage

// ----- sv/ubxd_if.sv -----
// Channel interfaces of the frame deframer: received bytes, result items and
// configuration writes. Each has valid/ready and a source and a sink modport.
// No dependencies.
interface ubxd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxd_item_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  data_byte;
  logic [7:0]  message_class;
  logic [7:0]  message_id;
  logic [15:0] byte_index;
  logic [1:0]  frame_status;

  modport source (output valid, output item_kind, output data_byte, output message_class,
                  output message_id, output byte_index, output frame_status, input ready);
  modport sink   (input valid, input item_kind, input data_byte, input message_class,
                  input message_id, input byte_index, input frame_status, output ready);
endinterface

interface ubxd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- sv/ubx_frame_deframer_unit.sv -----
// Frame deframer top level: sync hunt, header, payload tagging, Fletcher-8 check.
// Depends on ubxd_pkg and the interfaces in ubxd_if.sv.
//
//   channel | dir | payload                                   | request when
//   rx      | in  | rx_byte                                   | valid & ready
//   item    | out | item_kind, data_byte, message_class,      | valid & ready
//           |     | message_id, byte_index, frame_status      |
//   cfg     | in  | reg_index, wdata                          | valid & ready
//
// One byte per cycle sustained while the item channel takes results: an input
// register feeds the parser, whose next state and result are loaded together
// into the state and result registers. A byte passes through the input
// register and then the result register, which holds its result, if any.
// rst (synchronous) returns to sync hunting and loads the default sync bytes
// and maximum payload. A stalled result holds both stages; cfg is always ready.
module ubx_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  ubxd_byte_if.sink   rx,
  ubxd_item_if.source item,
  ubxd_cfg_if.sink    cfg
);
  import ubxd_pkg::*;

  // Configuration registers
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [15:0] max_payload;

  // Input stage
  logic       in_valid;
  logic [7:0] in_byte;

  // Parser state
  phase_t      phase, phase_next;
  logic [1:0]  header_count, header_count_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  class_hold, class_hold_next;
  logic [7:0]  id_hold, id_hold_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  received_check_a, received_check_a_next;

  // Result stage
  logic        out_valid;
  logic        emit;
  logic        kind_next;
  logic [7:0]  data_next;
  logic [15:0] index_next;
  logic [1:0]  status_next;

  logic        out_free;
  logic        step;
  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] count_inc;
  logic [15:0] full_length;

  assign out_free = !out_valid || item.ready;
  assign step     = in_valid && out_free;
  assign rx.ready = !in_valid || out_free;
  assign cfg.ready = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_SYNC_FIRST:  sync_first  <= cfg.wdata[7:0];
        REG_SYNC_SECOND: sync_second <= cfg.wdata[7:0];
        REG_MAX_PAYLOAD: max_payload <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Capture the incoming byte when the input stage is free
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Running Fletcher sum and helpers
  assign add_a       = sum_a + in_byte;
  assign add_b       = sum_b + add_a;
  assign count_inc   = payload_count + 16'd1;
  assign full_length = {in_byte, frame_length[7:0]};

  // Advance the parser by one byte
  always_comb begin
    phase_next            = phase;
    header_count_next     = header_count;
    frame_length_next     = frame_length;
    payload_count_next    = payload_count;
    class_hold_next       = class_hold;
    id_hold_next          = id_hold;
    sum_a_next            = sum_a;
    sum_b_next            = sum_b;
    received_check_a_next = received_check_a;
    emit        = 1'b0;
    kind_next   = KIND_PAYLOAD;
    data_next   = 8'd0;
    index_next  = 16'd0;
    status_next = STATUS_GOOD;
    case (phase)
      PH_SYNC: begin
        if (in_byte == sync_second) begin
          phase_next         = PH_HEAD;
          header_count_next  = HDR_CLASS;
          sum_a_next         = 8'd0;
          sum_b_next         = 8'd0;
          frame_length_next  = 16'd0;
          payload_count_next = 16'd0;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_HEAD: begin
        sum_a_next = add_a;
        sum_b_next = add_b;
        case (header_count)
          HDR_CLASS: begin
            class_hold_next   = in_byte;
            header_count_next = HDR_ID;
          end
          HDR_ID: begin
            id_hold_next      = in_byte;
            header_count_next = HDR_LEN_LO;
          end
          HDR_LEN_LO: begin
            frame_length_next = {8'd0, in_byte};
            header_count_next = HDR_LEN_HI;
          end
          default: begin
            frame_length_next  = full_length;
            header_count_next  = HDR_CLASS;
            payload_count_next = 16'd0;
            if (full_length > max_payload) begin
              // Abort an oversize frame right away
              phase_next  = PH_HUNT;
              emit        = 1'b1;
              kind_next   = KIND_END;
              index_next  = full_length;
              status_next = STATUS_TOO_LONG;
            end else if (full_length == 16'd0) begin
              phase_next = PH_CKA;
            end else begin
              phase_next = PH_PAY;
            end
          end
        endcase
      end
      PH_PAY: begin
        sum_a_next         = add_a;
        sum_b_next         = add_b;
        payload_count_next = count_inc;
        if (count_inc >= frame_length) begin
          phase_next = PH_CKA;
        end
        emit       = 1'b1;
        kind_next  = KIND_PAYLOAD;
        data_next  = in_byte;
        index_next = payload_count;
      end
      PH_CKA: begin
        received_check_a_next = in_byte;
        phase_next            = PH_CKB;
      end
      PH_CKB: begin
        phase_next  = PH_HUNT;
        emit        = 1'b1;
        kind_next   = KIND_END;
        index_next  = frame_length;
        status_next = (received_check_a == sum_a && in_byte == sum_b) ? STATUS_GOOD
                                                                      : STATUS_BAD;
      end
      default: begin
        phase_next = (in_byte == sync_first) ? PH_SYNC : PH_HUNT;
      end
    endcase
  end

  // Update parser state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      header_count     <= HDR_CLASS;
      frame_length     <= 16'd0;
      payload_count    <= 16'd0;
      class_hold       <= 8'd0;
      id_hold          <= 8'd0;
      sum_a            <= 8'd0;
      sum_b            <= 8'd0;
      received_check_a <= 8'd0;
    end else if (step) begin
      phase            <= phase_next;
      header_count     <= header_count_next;
      frame_length     <= frame_length_next;
      payload_count    <= payload_count_next;
      class_hold       <= class_hold_next;
      id_hold          <= id_hold_next;
      sum_a            <= sum_a_next;
      sum_b            <= sum_b_next;
      received_check_a <= received_check_a_next;
    end
  end

  // Load the result register; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      item.item_kind     <= kind_next;
      item.data_byte     <= data_next;
      item.message_class <= class_hold_next;
      item.message_id    <= id_hold_next;
      item.byte_index    <= index_next;
      item.frame_status  <= status_next;
    end
  end

  assign item.valid = out_valid;

`ifndef SYNTHESIS
  // A payload byte always yields a payload result in the next cycle
  a_pay_emits: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_PAY |=> out_valid && item.item_kind == KIND_PAYLOAD)
    else $error("payload byte did not produce a payload result");

  // Second checksum byte ends the frame and resumes the hunt
  a_ckb_ends: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_CKB |=> phase == PH_HUNT && out_valid && item.item_kind == KIND_END)
    else $error("checksum byte did not close the frame");

  // Payload counter never reaches the frame length while in payload
  a_pay_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAY |-> payload_count < frame_length)
    else $error("payload count overran frame length");

  // Reset leaves the block hunting with no result pending
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> phase == PH_HUNT && !out_valid && !in_valid)
    else $error("reset did not clear the parser");
`endif

endmodule
